@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable min priority queue: field widths,
// queue depth, result codes and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;

	localparam int ID_W   = 31;
	localparam int KEY_W  = 16;
	localparam int TAG_W  = 8;
	localparam int FILL_W = 5;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		RC_INSERTED = 2'd0,
		RC_POPPED   = 2'd1,
		RC_EMPTY    = 2'd2,
		RC_FULL     = 2'd3
	} result_code_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic         capture;
		logic         do_insert;
		logic         do_pop;
		result_code_t code;
	} spq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} spq_stat_t;

endpackage

@@ rtl/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: valid/ready handshake carrying one queue operation word.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             opcode;
	logic [ID_W-1:0]  item_id;
	logic [KEY_W-1:0] key_time;
	logic [TAG_W-1:0] status_tag;

	modport source (output valid, opcode, item_id, key_time, status_tag, input ready);
	modport sink   (input valid, opcode, item_id, key_time, status_tag, output ready);
endinterface

@@ rtl/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface spq_rsp_if import spq_pkg::*; ();
	logic              valid;
	logic              ready;
	result_code_t      result_code;
	logic [ID_W-1:0]   out_id;
	logic [KEY_W-1:0]  out_time;
	logic [TAG_W-1:0]  out_status;
	logic [FILL_W-1:0] fill_level;

	modport source (output valid, result_code, out_id, out_time, out_status, fill_level,
		input ready);
	modport sink   (input valid, result_code, out_id, out_time, out_status, fill_level,
		output ready);
endinterface

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts a request word, decides the result code and
// tells the datapath what to do, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_opcode,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_HOLD = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	// a held result that is being taken frees the output register this cycle
	assign req_ready = (state_q == ST_IDLE) || rsp_ready;
	assign rsp_valid = (state_q == ST_HOLD);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.capture   = accept;
		cmd.do_insert = 1'b0;
		cmd.do_pop    = 1'b0;
		cmd.code      = RC_INSERTED;
		if (req_opcode == OP_POP) begin
			if (stat.empty) begin
				cmd.code = RC_EMPTY;
			end else begin
				cmd.code   = RC_POPPED;
				cmd.do_pop = accept;
			end
		end else begin
			if (stat.full) begin
				cmd.code = RC_FULL;
			end else begin
				cmd.code      = RC_INSERTED;
				cmd.do_insert = accept;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (accept) state_d = ST_HOLD;
				else if (rsp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result still held");
	a_capture_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> rsp_valid)
		else $error("captured result not presented");
	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.do_insert && cmd.do_pop))
		else $error("insert and pop issued together");
`endif

endmodule

@@ rtl/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Sorted register array with per-cell compare and shift, entry counter and
// the result register.
// ----------------------------------------------------------------------------
module spq_dp import spq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_cmd_t          cmd,
	input  logic [ID_W-1:0]   item_id,
	input  logic [KEY_W-1:0]  key_time,
	input  logic [TAG_W-1:0]  status_tag,
	output spq_stat_t         stat,
	output result_code_t      result_code,
	output logic [ID_W-1:0]   out_id,
	output logic [KEY_W-1:0]  out_time,
	output logic [TAG_W-1:0]  out_status,
	output logic [FILL_W-1:0] fill_level
);

	entry_t             store_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [QUEUE_DEPTH-1:0] mv;
	entry_t             new_entry;

	result_code_t       res_code_q;
	entry_t             res_entry_q;
	logic [CNT_W-1:0]   res_cnt_q;

	assign new_entry = '{id: item_id, key: key_time, tag: status_tag};

	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.do_insert) cnt_d = cnt_q + CNT_W'(1);
		else if (cmd.do_pop) cnt_d = cnt_q - CNT_W'(1);
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		// cell moves on insert: held key larger than the new one, or first free slot
		assign mv[i] = ((cnt_q > CNT_W'(i)) && (store_q[i].key > key_time)) ||
			(cnt_q == CNT_W'(i));

		always_ff @(posedge clk) begin
			if (cmd.do_insert && mv[i]) begin
				if (i == 0) begin
					store_q[i] <= new_entry;
				end else if (mv[(i == 0) ? 0 : i-1]) begin
					store_q[i] <= store_q[(i == 0) ? 0 : i-1];
				end else begin
					store_q[i] <= new_entry;
				end
			end else if (cmd.do_pop && (i < QUEUE_DEPTH - 1)) begin
				store_q[i] <= store_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_code_q  <= cmd.code;
			res_entry_q <= cmd.do_pop ? store_q[0] : '0;
			res_cnt_q   <= cnt_d;
		end
	end

	assign result_code = res_code_q;
	assign out_id      = res_entry_q.id;
	assign out_time    = res_entry_q.key;
	assign out_status  = res_entry_q.tag;
	assign fill_level  = FILL_W'(res_cnt_q);

`ifndef SYNTHESIS
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) |-> store_q[0].key <= store_q[1].key)
		else $error("head entries out of order");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |=> cnt_q == ($past(cnt_q) + CNT_W'(1)))
		else $error("insert did not grow the queue");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.do_insert && !cmd.do_pop |=> cnt_q == $past(cnt_q))
		else $error("entry count changed without an operation");
`endif

endmodule

@@ rtl/stable_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded min priority queue on a delivery-time key, kept sorted in a
// register array; equal keys leave in arrival order.
//
// channel  dir  payload                                           handshake
// req      in   opcode, item_id, key_time, status_tag             valid/ready
// rsp      out  result_code, out_id, out_time, out_status,        valid/ready
//               fill_level
//
// one word per cycle: every cell compares against the new key in parallel and
// shifts in the same cycle, the result is registered and appears in the cycle
// after acceptance. the result register frees as it is taken, so back-to-back
// words flow while rsp is ready; a stalled rsp holds req off.
// reset clears the entry count and the handshake state; no clearing pass.
// ----------------------------------------------------------------------------
module stable_min_priority_queue import spq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	spq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item_id     (req.item_id),
		.key_time    (req.key_time),
		.status_tag  (req.status_tag),
		.stat        (stat),
		.result_code (rsp.result_code),
		.out_id      (rsp.out_id),
		.out_time    (rsp.out_time),
		.out_status  (rsp.out_status),
		.fill_level  (rsp.fill_level)
	);

endmodule
